[rtl/jerk_limited_speed_trajectory_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the speed trajectory planner
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef JERK_LIMITED_SPEED_TRAJECTORY_MACROS_SVH
`define JERK_LIMITED_SPEED_TRAJECTORY_MACROS_SVH

// Assert a property on an explicit clock, disabled while reset is low.
`define JLST_ASSERT_CR(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Assert a property on clk_i / rst_ni.
`define JLST_ASSERT(lbl, prop, msg) \
  `JLST_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/jlst_pkg.sv]
// ----------------------------------------------------------------------------
// jlst_pkg
// Shared types, constants and fixed-point helpers of the trajectory planner.
// ----------------------------------------------------------------------------
package jlst_pkg;

  localparam int FracBits = 16;

  // Working word: 34-bit signed, product: 68-bit signed.
  typedef logic signed [33:0] w_t;
  typedef logic signed [67:0] p_t;

  localparam w_t Two      = w_t'(2 ** (FracBits + 1));
  localparam w_t Half     = w_t'(2 ** (FracBits - 1));
  localparam w_t Five     = w_t'(5 * (2 ** FracBits));
  localparam w_t ATol     = w_t'((2 ** FracBits + 50) / 100);
  localparam w_t Rpm2Rad  = 34'sd449767923;
  localparam w_t Tenth    = 34'sd429496730;
  localparam w_t Fiftieth = 34'sd85899346;
  // ceil(2^35 / 6): exact floor division by six for operands below 2^32
  localparam w_t Recip6   = 34'sd5726623062;
  localparam int Recip6Sh = 35;
  localparam w_t Int32Max = 34'sd2147483647;
  localparam w_t Int32Min = -34'sd2147483648;

  localparam int StepCnt = 32;
  localparam int CntW    = $clog2(StepCnt);

  // Configuration register indexes
  localparam logic [2:0] CfgSpeed  = 3'd0;
  localparam logic [2:0] CfgAccel  = 3'd1;
  localparam logic [2:0] CfgJerk   = 3'd2;
  localparam logic [2:0] CfgTick   = 3'd3;
  localparam logic [2:0] CfgSettle = 3'd4;
  localparam logic [2:0] CfgStopT  = 3'd5;

  typedef enum logic [1:0] {
    CASE_STUCK   = 2'd0,
    CASE_GENTLE  = 2'd1,
    CASE_SETTLED = 2'd2,
    CASE_RAMP    = 2'd3
  } case_e;

  // Multiplier operations
  typedef enum logic [4:0] {
    OP_T2, OP_T3, OP_SMAX, OP_AMAX, OP_JMAX, OP_TGT, OP_MEAS,
    OP_CORR, OP_INCP, OP_INCS, OP_SQIN,
    OP_VA, OP_VJ, OP_AJ, OP_I1, OP_I2, OP_I3, OP_I6
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_in;
    logic mul_issue;
    logic mul_wb;
    logic decide;
    logic sqrt_step;
    logic des;
    logic div_step;
    logic jsel;
    logic snap;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic pull;
    logic settle;
    logic skip_div;
  } sts_t;

  // Round to nearest, ties toward plus infinity, then arithmetic shift.
  function automatic w_t rnd_sh(p_t p, int s);
    p_t r;
    r = (p + (p_t'(1) <<< (s - 1))) >>> s;
    return w_t'(r);
  endfunction

  function automatic w_t clampw(w_t v, w_t lo, w_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

[rtl/jerk_limited_speed_trajectory.sv]
// ----------------------------------------------------------------------------
// jerk_limited_speed_trajectory
// Jerk-limited S-curve speed planner with pull-back toward the measurement.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata 120b, tuser 1b
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata 152b, tuser 2b
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i 3b, cfg_data_i 32b
//
// One beat at a time. A ramping beat runs the 32-step sqrt, and the 32-step
// divider too when the jerk request needs it; pull-back and settled beats
// skip both. Every product goes through one shared multiplier.
// A finished result waits in the output register while the next beat runs.
// Reset is asynchronous, active low; it restores the register defaults and
// clears the plan. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module jerk_limited_speed_trajectory import jlst_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] target_speed_rpm, [63:32] measured_speed_rpm,
  // [111:64] measured_position, [112] reinit, [119:113] zero
  input  logic [119:0]  s_axis_tdata,
  // [0] measured_speed_bad
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] velocity_ref, [63:32] accel_ref, [95:64] jerk_ref,
  // [143:96] position_ref, [144] motor_stopped, [151:145] zero
  output logic [151:0]  m_axis_tdata,
  // [1:0] plan_case
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  logic signed [31:0] vel, acc, jrk;
  logic signed [47:0] pos;
  logic stopped;
  logic [1:0] pcase;

  // Config is never back-pressured.
  assign cfg_ready_o = 1'b1;

  jlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jlst_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_target_i     (s_axis_tdata[31:0]),
    .in_meas_i       (s_axis_tdata[63:32]),
    .in_bad_i        (s_axis_tuser[0]),
    .in_pos_i        (s_axis_tdata[111:64]),
    .in_reinit_i     (s_axis_tdata[112]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .velocity_ref_o  (vel),
    .accel_ref_o     (acc),
    .jerk_ref_o      (jrk),
    .position_ref_o  (pos),
    .motor_stopped_o (stopped),
    .plan_case_o     (pcase)
  );

  // Pack the result beat; pad bits stay zero.
  assign m_axis_tdata = {7'd0, stopped, pos, jrk, acc, vel};
  assign m_axis_tuser = pcase;

endmodule

[rtl/jlst_ctrl.sv]
// ----------------------------------------------------------------------------
// jlst_ctrl
// Sequencer of the planner: steps the shared multiplier, sqrt and divider.
// ----------------------------------------------------------------------------
module jlst_ctrl import jlst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL0   = 10'b00_0000_0010,
    ST_MUL1   = 10'b00_0000_0100,
    ST_DECIDE = 10'b00_0000_1000,
    ST_SQRT   = 10'b00_0001_0000,
    ST_DES    = 10'b00_0010_0000,
    ST_DIV    = 10'b00_0100_0000,
    ST_JSEL   = 10'b00_1000_0000,
    ST_SNAP   = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic cnt_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_last = (cnt_q == CntW'(StepCnt - 1));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = OP_T2;
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: begin
        state_d = ST_MUL0;
        case (op_q)
          OP_T2:   op_d = OP_T3;
          OP_T3:   op_d = OP_SMAX;
          OP_SMAX: op_d = OP_AMAX;
          OP_AMAX: op_d = OP_JMAX;
          OP_JMAX: op_d = OP_TGT;
          OP_TGT:  op_d = OP_MEAS;
          OP_MEAS: state_d = ST_DECIDE;
          OP_CORR: op_d = OP_INCP;
          OP_SQIN: begin
            cnt_d   = '0;
            state_d = ST_SQRT;
          end
          OP_VA:   op_d = OP_VJ;
          OP_VJ:   op_d = OP_AJ;
          OP_AJ:   state_d = ST_SNAP;
          OP_I1:   op_d = OP_I2;
          OP_I2:   op_d = OP_I3;
          OP_I3:   op_d = OP_I6;
          default: state_d = ST_FIN;
        endcase
      end
      ST_DECIDE: begin
        state_d = ST_MUL0;
        if (sts_i.pull) begin
          op_d = OP_CORR;
        end else if (sts_i.settle) begin
          op_d = OP_INCS;
        end else begin
          op_d = OP_SQIN;
        end
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_DES;
        end
      end
      ST_DES: begin
        cnt_d   = '0;
        state_d = sts_i.skip_div ? ST_JSEL : ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_JSEL;
        end
      end
      ST_JSEL: begin
        op_d    = OP_VA;
        state_d = ST_MUL0;
      end
      ST_SNAP: begin
        op_d    = OP_I1;
        state_d = ST_MUL0;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_T2;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_issue = (state_q == ST_MUL0);
    cmd_o.mul_wb    = (state_q == ST_MUL1);
    cmd_o.decide    = (state_q == ST_DECIDE);
    cmd_o.sqrt_step = (state_q == ST_SQRT);
    cmd_o.des       = (state_q == ST_DES);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.jsel      = (state_q == ST_JSEL);
    cmd_o.snap      = (state_q == ST_SNAP);
    cmd_o.fin       = (state_q == ST_FIN) && out_free;
  end

endmodule

[rtl/jlst_datapath.sv]
// ----------------------------------------------------------------------------
// jlst_datapath
// Registers, shared multiplier, sqrt and divide steps of the planner.
// ----------------------------------------------------------------------------
module jlst_datapath import jlst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] in_target_i,
  input  logic signed [31:0] in_meas_i,
  input  logic               in_bad_i,
  input  logic signed [47:0] in_pos_i,
  input  logic               in_reinit_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic signed [31:0] velocity_ref_o,
  output logic signed [31:0] accel_ref_o,
  output logic signed [31:0] jerk_ref_o,
  output logic signed [47:0] position_ref_o,
  output logic               motor_stopped_o,
  output logic [1:0]         plan_case_o
);

  // Configuration
  logic [30:0] spd_q, acc_q, jrk_q, tol_q;
  logic [31:0] tp_q;
  logic [15:0] stk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_q <= 31'd196608000;
      acc_q <= 31'd65536000;
      jrk_q <= 31'd327680000;
      tp_q  <= 32'd429497;
      tol_q <= 31'd6554;
      stk_q <= 16'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSpeed:  spd_q <= cfg_data_i[30:0];
        CfgAccel:  acc_q <= cfg_data_i[30:0];
        CfgJerk:   jrk_q <= cfg_data_i[30:0];
        CfgTick:   tp_q  <= cfg_data_i;
        CfgSettle: tol_q <= cfg_data_i[30:0];
        CfgStopT:  stk_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] tval;
  w_t t_w;
  assign tval = (tp_q == 32'd0) ? 32'd1 : tp_q;
  assign t_w  = $signed({2'b00, tval});

  // Latched input beat
  logic signed [31:0] in_tgt_q, in_meas_q;
  logic signed [47:0] in_pos_q;
  logic in_bad_q, in_reinit_q;

  // Plan state
  logic signed [31:0] pv_q, pa_q, pj_q;
  logic [47:0] pp_q;
  logic [30:0] deb_q;

  // Work registers
  logic [31:0] t2_q, t3_q;
  w_t smax_q, amax_q, jmax_q, tgt_q, meas_q, act_q, gap_q, mag_q;
  w_t pvn_q, m1_q, m2_q, m3_q, i1_q, i2_q, iabs_q, vn_q, an_q, j_q;
  logic up_q, stopped_q, ineg_q, dneg_q, skip_q;
  case_e case_q;
  p_t prod_q;
  logic [63:0] sqx_q;
  logic [35:0] srem_q;
  logic [31:0] root_q, quo_q;
  logic [32:0] drem_q;
  logic signed [47:0] inc_q;

  // Operand select and multiply
  w_t op_a, op_b, lim_w, tin_w;
  assign lim_w = $signed({3'b000, spd_q});
  assign tin_w = clampw(w_t'(in_tgt_q), -lim_w, lim_w);

  always_comb begin
    op_a = t_w;
    op_b = t_w;
    case (cmd_i.op)
      OP_T2:   begin op_a = t_w;                        op_b = t_w;      end
      OP_T3:   begin op_a = $signed({2'b00, t2_q});     op_b = t_w;      end
      OP_SMAX: begin op_a = $signed({3'b000, spd_q});   op_b = Rpm2Rad;  end
      OP_AMAX: begin op_a = $signed({3'b000, acc_q});   op_b = Rpm2Rad;  end
      OP_JMAX: begin op_a = $signed({3'b000, jrk_q});   op_b = Rpm2Rad;  end
      OP_TGT:  begin op_a = tin_w;                      op_b = Rpm2Rad;  end
      OP_MEAS: begin op_a = w_t'(in_meas_q);            op_b = Rpm2Rad;  end
      OP_CORR: begin op_a = gap_q; op_b = stopped_q ? Tenth : Fiftieth;  end
      OP_INCP: begin op_a = clampw(pvn_q, Int32Min, Int32Max); op_b = t_w; end
      OP_INCS: begin op_a = tgt_q;                      op_b = t_w;      end
      OP_SQIN: begin op_a = mag_q;                      op_b = jmax_q;   end
      OP_VA:   begin op_a = w_t'(pa_q);                 op_b = t_w;      end
      OP_VJ:   begin op_a = j_q; op_b = $signed({2'b00, t2_q});          end
      OP_AJ:   begin op_a = j_q;                        op_b = t_w;      end
      OP_I1:   begin op_a = w_t'(pv_q);                 op_b = t_w;      end
      OP_I2:   begin op_a = w_t'(pa_q); op_b = $signed({2'b00, t2_q});   end
      OP_I3:   begin op_a = j_q; op_b = $signed({2'b00, t3_q});          end
      OP_I6:   begin op_a = iabs_q;                     op_b = Recip6;   end
      default: ;
    endcase
  end

  w_t ra32, ra33, q6;
  assign ra32 = rnd_sh(prod_q, 32);
  assign ra33 = rnd_sh(prod_q, 33);
  assign q6   = w_t'(prod_q >>> Recip6Sh);

  // Pull-back velocity
  w_t corr, pv1;
  always_comb begin
    if (stopped_q) begin
      corr = (ra32 > Two) ? Two : ra32;
      pv1  = w_t'(pv_q) - corr;
      if (pv1 < tgt_q) pv1 = tgt_q;
      if (pv1 < act_q + Half) pv1 = act_q + Half;
      if (tgt_q > 0 && pv1 < 0) pv1 = '0;
    end else begin
      corr = (ra32 > Half) ? Half : ra32;
      pv1  = w_t'(pv_q) - corr;
      if (pv1 < tgt_q) pv1 = tgt_q;
    end
  end

  // Decide step
  w_t pvr, par, actc, gapc, errc, magc, meas_sx;
  logic [30:0] deb_n;
  logic stop_n, still;
  always_comb begin
    meas_sx = w_t'(in_meas_q);
    pvr  = in_reinit_q ? (in_bad_q ? '0 : meas_q) : w_t'(pv_q);
    par  = in_reinit_q ? '0 : w_t'(pa_q);
    actc = in_bad_q ? pvr : meas_q;
    gapc = pvr - actc;
    errc = tgt_q - pvr;
    magc = (errc < 0) ? -errc : errc;
    still = in_bad_q || (meas_sx < Five && meas_sx > -Five);
    if (still) begin
      deb_n = (deb_q == '1) ? deb_q : deb_q + 1'b1;
    end else begin
      deb_n = '0;
    end
    stop_n = ({1'b0, deb_n} > {16'd0, stk_q});
    if (stop_n) deb_n = '0;
  end

  assign sts_o.pull   = (gapc > Two);
  assign sts_o.settle = (magc < $signed({3'b000, tol_q})) && (par < ATol) && (par > -ATol);

  // Desired acceleration and jerk request
  w_t stop_w, des0, des1, diffc, dmc;
  always_comb begin
    stop_w = $signed({2'b00, root_q});
    des0   = (amax_q < stop_w) ? amax_q : stop_w;
    des1   = up_q ? des0 : -des0;
    if (act_q < w_t'(pv_q) && des1 > 0) des1 = des1 >>> 1;
    des1   = clampw(des1, -amax_q, amax_q);
    diffc  = des1 - w_t'(pa_q);
    dmc    = (diffc < 0) ? -diffc : diffc;
  end
  assign sts_o.skip_div = (dmc[33:31] != 3'b000) || (dmc >= t_w);

  // Sqrt and divide steps
  logic [35:0] rem_n, trial;
  logic [32:0] r2;
  assign rem_n = {srem_q[33:0], sqx_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign r2    = {drem_q[31:0], 1'b0};

  w_t qsel, vnc, anc, incr;
  always_comb begin
    if (skip_q || ($signed({2'b00, quo_q}) >= jmax_q)) begin
      qsel = jmax_q;
    end else begin
      qsel = $signed({2'b00, quo_q});
    end
    vnc  = clampw(w_t'(pv_q) + m1_q + m2_q, -smax_q, smax_q);
    anc  = clampw(w_t'(pa_q) + m3_q, -amax_q, amax_q);
    incr = i1_q + i2_q + (ineg_q ? -q6 : q6);
  end

  // Final plan values
  w_t pv_f, pa_f, pj_f;
  always_comb begin
    case (case_q)
      CASE_STUCK, CASE_GENTLE: begin
        pv_f = clampw(pvn_q, -smax_q, smax_q);
        pa_f = '0;
        pj_f = '0;
      end
      CASE_SETTLED: begin
        pv_f = tgt_q;
        pa_f = '0;
        pj_f = '0;
      end
      default: begin
        pv_f = vn_q;
        pa_f = an_q;
        pj_f = j_q;
      end
    endcase
  end

  logic [47:0] pp_f;
  assign pp_f = pp_q + inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      pa_q  <= '0;
      pj_q  <= '0;
      pp_q  <= '0;
      deb_q <= '0;
    end else if (cmd_i.decide) begin
      pv_q  <= pvr[31:0];
      pa_q  <= par[31:0];
      deb_q <= deb_n;
      if (in_reinit_q) begin
        pj_q <= '0;
        pp_q <= in_pos_q;
      end
    end else if (cmd_i.fin) begin
      pv_q <= pv_f[31:0];
      pa_q <= pa_f[31:0];
      pj_q <= pj_f[31:0];
      pp_q <= pp_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_tgt_q    <= in_target_i;
      in_meas_q   <= in_meas_i;
      in_bad_q    <= in_bad_i;
      in_pos_q    <= in_pos_i;
      in_reinit_q <= in_reinit_i;
    end
    if (cmd_i.mul_issue) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.mul_wb) begin
      case (cmd_i.op)
        OP_T2:   t2_q   <= ra32[31:0];
        OP_T3:   t3_q   <= ra32[31:0];
        OP_SMAX: smax_q <= ra32;
        OP_AMAX: amax_q <= ra32;
        OP_JMAX: jmax_q <= ra32;
        OP_TGT:  tgt_q  <= clampw(ra32, -smax_q, smax_q);
        OP_MEAS: meas_q <= ra32;
        OP_CORR: pvn_q  <= pv1;
        OP_INCP, OP_INCS: inc_q <= {{14{ra32[33]}}, ra32};
        OP_SQIN: begin
          sqx_q  <= {prod_q[62:0], 1'b0};
          srem_q <= '0;
          root_q <= '0;
        end
        OP_VA:   m1_q <= ra32;
        OP_VJ:   m2_q <= ra33;
        OP_AJ:   m3_q <= ra32;
        OP_I1:   i1_q <= ra32;
        OP_I2:   i2_q <= ra33;
        OP_I3: begin
          ineg_q <= (ra32 < 0);
          iabs_q <= (ra32 < 0) ? -ra32 : ra32;
        end
        OP_I6:   inc_q <= {{14{incr[33]}}, incr};
        default: ;
      endcase
    end
    if (cmd_i.decide) begin
      act_q     <= actc;
      gap_q     <= gapc;
      mag_q     <= magc;
      up_q      <= (errc >= 0);
      stopped_q <= stop_n;
      if (sts_o.pull) begin
        case_q <= stop_n ? CASE_STUCK : CASE_GENTLE;
      end else if (sts_o.settle) begin
        case_q <= CASE_SETTLED;
      end else begin
        case_q <= CASE_RAMP;
      end
    end
    if (cmd_i.sqrt_step) begin
      sqx_q <= {sqx_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        srem_q <= rem_n - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= rem_n;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.des) begin
      dneg_q <= (diffc < 0);
      drem_q <= dmc[32:0];
      quo_q  <= '0;
      skip_q <= sts_o.skip_div;
    end
    if (cmd_i.div_step) begin
      if (r2 >= {1'b0, tval}) begin
        drem_q <= r2 - {1'b0, tval};
        quo_q  <= {quo_q[30:0], 1'b1};
      end else begin
        drem_q <= r2;
        quo_q  <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.jsel) begin
      j_q <= dneg_q ? -qsel : qsel;
    end
    if (cmd_i.snap) begin
      if ((up_q && vnc > tgt_q) || (!up_q && vnc < tgt_q)) begin
        vn_q <= tgt_q;
        an_q <= '0;
        j_q  <= '0;
      end else begin
        vn_q <= vnc;
        an_q <= anc;
      end
    end
    if (cmd_i.fin) begin
      velocity_ref_o  <= pv_f[31:0];
      accel_ref_o     <= pa_f[31:0];
      jerk_ref_o      <= pj_f[31:0];
      position_ref_o  <= pp_f;
      motor_stopped_o <= stopped_q;
      plan_case_o     <= case_q;
    end
  end

endmodule

[rtl/jlst_checker.sv]
// ----------------------------------------------------------------------------
// jlst_checker
// Port-level checks of the trajectory planner, bound to the top level.
// ----------------------------------------------------------------------------
`include "jerk_limited_speed_trajectory_macros.svh"

module jlst_checker import jlst_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A stalled result beat holds.
  `JLST_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result beat changed while stalled")

  // Only one beat in flight: busy right after accepting.
  `JLST_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while a beat is in work")

  // A result never appears the cycle after an input beat is accepted.
  `JLST_ASSERT(a_min_latency, $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready), "result too early")

  // Pull-back and settled cases carry zero acceleration and jerk.
  `JLST_ASSERT(a_zero_aj, (m_axis_tvalid && m_axis_tuser != CASE_RAMP) |-> (m_axis_tdata[95:32] == 64'd0), "nonzero accel or jerk outside ramping")

endmodule

bind jerk_limited_speed_trajectory jlst_checker u_jlst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
